### rtl/core/nv21r_pkg.sv
// shared constants and types for the nv21 region 180-degree rotator
// no dependencies; imported by every module of the block but nv21r_ram
package nv21r_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT / 2 * 3;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int DIM_W       = 11;
  localparam int CFG_IDX_W   = 1;
  localparam int BYTE_W      = 8;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  // cycles the input stays closed after a register write while sizes settle
  localparam logic [1:0] SETTLE_CYCLES = 2'd3;

  // per-beat control passed from the sequencer to the output stage
  typedef struct packed {
    logic emit;  // a full previous region is stored, the read byte is a result
    logic last;  // last byte of the region
  } step_t;

  // clamp a written size into 2..max and force it even
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] val,
                                                 input int max_dim);
    logic [DIM_W-1:0] v;
    v = val;
    if (int'(v) < 2) v = DIM_W'(2);
    if (int'(v) > max_dim) v = DIM_W'(max_dim);
    return {v[DIM_W-1:1], 1'b0};
  endfunction

endpackage

### rtl/core/nv21r_ram.sv
// generic single-port synchronous ram, read-first, registered read data
// no dependencies
module nv21r_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/nv21r_seq.sv
// sequencer: size registers, byte position, store address and direction
// depends on nv21r_pkg
module nv21r_seq
  import nv21r_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DIM_W-1:0]     cfg_wdata_i,
  input  logic                 accept_i,
  output logic                 cfg_ready_o,
  output logic [ADDR_W-1:0]    addr_o,
  output step_t                step_o
);

  logic [DIM_W-1:0]  width_q, width_d, height_q, height_d;
  logic [ADDR_W-1:0] luma_q, luma_m1_q, size_m1_q;
  logic [ADDR_W:0]   chroma_base_q;
  logic [2*DIM_W-1:0] area;
  logic [ADDR_W:0]   luma_x;
  logic [1:0]        settle_q, settle_d;
  logic [ADDR_W-1:0] pos_q, pos_d;
  logic              rev_q, rev_d, primed_q, primed_d;
  logic              last;
  logic [ADDR_W:0]   chroma_addr;
  logic [ADDR_W-1:0] rot_addr;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_WIDTH:  width_d  = clamp_dim(cfg_wdata_i, MAX_WIDTH);
        REG_HEIGHT: height_d = clamp_dim(cfg_wdata_i, MAX_HEIGHT);
        default: ;
      endcase
    end
  end

  assign area   = width_q * height_q;
  assign luma_x = {1'b0, luma_q};

  // sizes derived over two register stages after each write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= clamp_dim(DIM_W'(1024), MAX_WIDTH);
      height_q <= clamp_dim(DIM_W'(1024), MAX_HEIGHT);
      settle_q <= SETTLE_CYCLES;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      settle_q <= settle_d;
    end
  end

  always_ff @(posedge clk_i) begin
    luma_q        <= ADDR_W'(area);
    luma_m1_q     <= luma_q - ADDR_W'(1);
    size_m1_q     <= luma_q + (luma_q >> 1) - ADDR_W'(1);
    // luma + chroma - 2 + luma: base of the reversed chroma addressing
    chroma_base_q <= luma_x + luma_x + (luma_x >> 1) - (ADDR_W+1)'(2);
  end

  always_comb begin
    settle_d = settle_q;
    if (cfg_we_i) begin
      settle_d = SETTLE_CYCLES;
    end else if (settle_q != 2'd0) begin
      settle_d = settle_q - 2'd1;
    end
  end

  assign cfg_ready_o = (settle_q == 2'd0);

  // reversed order: luma fully reversed, chroma reversed by vu pairs
  assign chroma_addr = chroma_base_q - {1'b0, pos_q} + {{(ADDR_W-1){1'b0}}, pos_q[0], 1'b0};
  assign rot_addr    = (pos_q <= luma_m1_q) ? (luma_m1_q - pos_q) : chroma_addr[ADDR_W-1:0];
  assign addr_o      = rev_q ? rot_addr : pos_q;

  assign last        = (pos_q == size_m1_q);
  assign step_o.emit = primed_q;
  assign step_o.last = last;

  always_comb begin
    pos_d    = pos_q;
    rev_d    = rev_q;
    primed_d = primed_q;
    if (cfg_we_i) begin
      pos_d    = '0;
      rev_d    = 1'b0;
      primed_d = 1'b0;
    end else if (accept_i) begin
      if (last) begin
        pos_d    = '0;
        rev_d    = !rev_q;
        primed_d = 1'b1;
      end else begin
        pos_d = pos_q + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      rev_q    <= 1'b0;
      primed_q <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      rev_q    <= rev_d;
      primed_q <= primed_d;
    end
  end

endmodule

### rtl/core/nv21r_out.sv
// output side: holds the ram read beat, then an output register toward the sink
// depends on nv21r_pkg
module nv21r_out
  import nv21r_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  step_t             step_i,
  input  logic [BYTE_W-1:0] rdata_i,
  input  logic              m_tready_i,
  output logic              free_o,
  output logic              rd_busy_o,
  output logic              m_tvalid_o,
  output logic [BYTE_W-1:0] m_tdata_o,
  output logic              m_tlast_o
);

  logic              rd_valid_q, rd_valid_d, rd_last_q;
  logic              out_valid_q, out_valid_d, out_last_q;
  logic [BYTE_W-1:0] out_byte_q;
  logic              out_load;

  // the ram read register holds its data until the next access
  assign out_load = rd_valid_q && (!out_valid_q || m_tready_i);
  assign free_o   = !rd_valid_q || out_load;

  always_comb begin
    rd_valid_d = rd_valid_q;
    if (load_i) begin
      rd_valid_d = step_i.emit;
    end else if (out_load) begin
      rd_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_valid_q  <= rd_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rd_last_q <= step_i.last;
    end
    if (out_load) begin
      out_byte_q <= rdata_i;
      out_last_q <= rd_last_q;
    end
  end

  assign rd_busy_o  = rd_valid_q;
  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_byte_q;
  assign m_tlast_o  = out_last_q;

endmodule

### rtl/core/nv21_region_rotate_180.sv
// nv21 region rotator, 180 degrees, streaming
//
// Input beats on s_axis carry one region byte each: region_height luma rows of
// region_width bytes, then region_height/2 rows of interleaved v,u bytes.
// For every input beat one byte of the previous region, rotated by 180
// degrees, leaves on m_axis in raster order; tlast marks its last byte.
// While the first region after reset or a register write streams in, no
// output beats appear. Luma is fully reversed, chroma by whole vu pairs.
// Throughput is one beat per cycle while m_axis is ready: each beat is one
// read-first access of the single-port frame store at the address where the
// next region's byte is written. A beat passes the read stage, then the
// output register. When m_axis stalls, one beat waits in the read stage and
// one in the output register, and s_axis tready drops until the read stage
// can move on. Register writes (cfg_we_i, cfg_index_i 0 = width, 1 = height)
// restart the stream; s_axis tready stays low after a write and after reset
// while the derived sizes settle. The store is not cleared at reset.
// depends on nv21r_pkg, nv21r_ram, nv21r_seq, nv21r_out
module nv21_region_rotate_180
  import nv21r_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DIM_W-1:0]     cfg_wdata_i,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [BYTE_W-1:0]    s_axis_tdata_i,   // [7:0] pixel_byte
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [BYTE_W-1:0]    m_axis_tdata_o,   // [7:0] out_byte
  output logic                 m_axis_tlast_o    // region_end
);

  logic              accept;
  logic              cfg_ready;
  logic              out_free;
  logic              rd_busy;
  logic [ADDR_W-1:0] addr;
  logic [BYTE_W-1:0] rdata;
  step_t             step;

  assign s_axis_tready_o = cfg_ready && out_free;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  nv21r_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .cfg_ready_o (cfg_ready),
    .addr_o      (addr),
    .step_o      (step)
  );

  nv21r_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .en_i    (accept),
    .we_i    (accept),
    .addr_i  (addr),
    .wdata_i (s_axis_tdata_i),
    .rdata_o (rdata)
  );

  nv21r_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (accept),
    .step_i     (step),
    .rdata_i    (rdata),
    .m_tready_i (m_axis_tready_i),
    .free_o     (out_free),
    .rd_busy_o  (rd_busy),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tlast_o  (m_axis_tlast_o)
  );

  // a register write keeps the input closed while sizes settle
  a_cfg_closes_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !s_axis_tready_o)
    else $error("input open right after a register write");

  // a beat that produces no result leaves the read stage empty
  a_no_emit_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !step.emit |=> !rd_busy)
    else $error("read stage holds a beat that has no result");

  // finishing a region primes the store for output
  a_last_primes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && step.last && !cfg_we_i |=> step.emit)
    else $error("store not primed after a full region");

endmodule

### tb/nv21_region_rotate_180_tb.sv
// self-checking testbench for the nv21 180-degree region rotator
// predicts every rotated beat from its own copy of the frame store and checks
// the m_axis stream; depends on nv21r_pkg and nv21_region_rotate_180
`timescale 1ns / 1ps

module nv21_region_rotate_180_tb;
  import nv21r_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int SMALL_BEATS  = 1400;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              last;
  } rot_beat_t;

  class rot180_predictor;
    logic [BYTE_W-1:0] frame_copy [];
    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    int unsigned       pos;
    bit                reversed;
    bit                primed;
    rot_beat_t         rotated_q [$];
    int                errors;
    int                pixels_in;
    int                rotated_out;
    int                reg_writes;

    function new();
      frame_copy = new[STORE_DEPTH];
      width_reg  = DIM_W'(MAX_WIDTH);
      height_reg = DIM_W'(MAX_HEIGHT);
      rewind();
    endfunction

    function void rewind();
      pos      = 0;
      reversed = 1'b0;
      primed   = 1'b0;
    endfunction

    function int unsigned usable_dim(logic [DIM_W-1:0] r, int unsigned lim);
      int unsigned v;
      v = r;
      if (v < 2) v = 2;
      if (v > lim) v = lim;
      return v & ~32'd1;
    endfunction

    function int unsigned region_bytes();
      int unsigned luma;
      luma = usable_dim(width_reg, MAX_WIDTH) * usable_dim(height_reg, MAX_HEIGHT);
      return luma + luma / 2;
    endfunction

    function int unsigned mirror_addr(int unsigned p, int unsigned luma,
                                      int unsigned chroma);
      int unsigned q;
      if (p < luma) return luma - 1 - p;
      q = p - luma;
      // whole vu pairs trade places, the byte order inside a pair is kept
      return luma + chroma - 2 - (q & ~32'd1) + (q & 32'd1);
    endfunction

    function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
      reg_writes++;
      if (idx == REG_WIDTH) width_reg = val;
      else if (idx == REG_HEIGHT) height_reg = val;
      rewind();
    endfunction

    function void note_pixel(logic [BYTE_W-1:0] b);
      int unsigned size;
      int unsigned luma;
      int unsigned addr;
      rot_beat_t   beat;
      size = region_bytes();
      luma = size / 3 * 2;
      if (pos >= size) pos = 0;
      addr = reversed ? mirror_addr(pos, luma, luma / 2) : pos;
      beat.data = frame_copy[addr];
      beat.last = (pos == size - 1);
      frame_copy[addr] = b;
      pixels_in++;
      if (primed) rotated_q.push_back(beat);
      if (beat.last) begin
        pos      = 0;
        reversed = !reversed;
        primed   = 1'b1;
      end else begin
        pos++;
      end
    endfunction

    function int pending();
      return rotated_q.size();
    endfunction

    task report(string what);
      $display("ERROR: rotated beat %0d: %s", rotated_out, what);
      errors++;
    endtask

    task check_rotated(logic [BYTE_W-1:0] d, logic l);
      rot_beat_t want;
      rotated_out++;
      if (rotated_q.size() == 0) begin
        report("output beat with no byte expected");
        return;
      end
      want = rotated_q.pop_front();
      if (d !== want.data) report($sformatf("out_byte %h, expected %h", d, want.data));
      if (l !== want.last) report($sformatf("region_end %b, expected %b", l, want.last));
    endtask
  endclass

  logic                 clk_i     = 1'b0;
  logic                 rst_ni    = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_wdata = '0;
  logic                 s_tvalid  = 1'b0;
  logic [BYTE_W-1:0]    s_tdata   = '0;
  logic                 s_tready;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b1;
  logic [BYTE_W-1:0]    m_tdata;
  logic                 m_tlast;

  rot180_predictor rotor;
  bit tx_gaps     = 1'b0;
  bit rx_stalls   = 1'b0;
  int stall_left  = 0;
  int idle_cycles = 0;
  int small_beats = 0;

  byte unsigned dir_bytes [12] = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE,
                                   8'h55, 8'hAA, 8'h0F, 8'hF0, 8'hC3, 8'h3C};

  nv21_region_rotate_180 DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),     // [7:0] pixel_byte
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),     // [7:0] out_byte
    .m_axis_tlast_o  (m_tlast)      // region_end
  );

  always #4 clk_i = ~clk_i;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 1;
    if (r < 85) return $urandom_range(2, 4);
    if (r < 97) return $urandom_range(5, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_dim();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r == 1) return 1;
    if (r == 2) return $urandom_range(3, 15) | 1;
    return 2 * $urandom_range(1, 6);
  endfunction

  always @(negedge clk_i) begin
    if (rx_stalls && stall_left == 0 && $urandom_range(0, 5) == 0) stall_left = pick_gap();
    if (stall_left > 0) begin
      m_tready = 1'b0;
      stall_left--;
    end else begin
      m_tready = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_tvalid === 1'b1 && m_tready) rotor.check_rotated(m_tdata, m_tlast);
      if (cfg_we) rotor.apply_write(cfg_index, cfg_wdata);
      if (s_tvalid && s_tready === 1'b1) rotor.note_pixel(s_tdata);
      if ((m_tvalid === 1'b1 && m_tready) || (s_tvalid && s_tready === 1'b1))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("end of test: mismatches");
    $finish;
  end

  task automatic send_pixel(input logic [BYTE_W-1:0] b);
    int gap;
    gap = (tx_gaps && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
    repeat (gap) begin
      @(negedge clk_i);
      s_tvalid = 1'b0;
    end
    @(negedge clk_i);
    s_tvalid = 1'b1;
    s_tdata  = b;
    do @(posedge clk_i); while (s_tready !== 1'b1);
  endtask

  task automatic hold_for_results();
    @(negedge clk_i);
    s_tvalid = 1'b0;
    while (rotor.pending() != 0) @(posedge clk_i);
  endtask

  task automatic stream_random(input int n);
    repeat (n) begin
      if ($urandom_range(0, 399) == 0) hold_for_results();
      send_pixel(BYTE_W'($urandom_range(0, 255)));
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = DIM_W'(val);
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  // only touch the registers once the pipe has emptied
  task automatic configure_sizes(input int w, input int h, input bit do_w, input bit do_h);
    hold_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (do_w) write_reg(REG_WIDTH, w);
    if (do_h) write_reg(REG_HEIGHT, h);
  endtask

  task automatic small_phase();
    int sel;
    int n;
    int w;
    int h;
    w = pick_dim();
    h = pick_dim();
    sel = $urandom_range(0, 5);
    tx_gaps   = $urandom_range(0, 3) != 0;
    rx_stalls = $urandom_range(0, 3) != 0;
    configure_sizes(w, h, sel != 1, sel != 0);
    n = $urandom_range(1, 3) * rotor.region_bytes();
    if ($urandom_range(0, 1)) n += $urandom_range(0, rotor.region_bytes() - 1);
    stream_random(n);
    small_beats += n;
  endtask

  task automatic large_phase(input int w, input int h);
    tx_gaps   = $urandom_range(0, 1) != 0;
    rx_stalls = $urandom_range(0, 1) != 0;
    configure_sizes(w, h, 1'b1, 1'b1);
    stream_random($urandom_range(30, 50));
  endtask

  initial begin
    rotor = new();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // partial region at the reset sizes, then a restart
    send_pixel(8'h00);
    send_pixel(8'hFF);

    configure_sizes(2, 2, 1'b1, 1'b1);
    for (int i = 0; i < 12; i++) begin
      if (i == 9) hold_for_results();
      send_pixel(dir_bytes[i]);
    end

    // sizes below the range clamp up to 2x2
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    configure_sizes(1, 0, 1'b1, 1'b1);
    stream_random(12);

    while (small_beats < SMALL_BEATS) small_phase();

    // widest and tallest sizes, the width clamped from above, as partial regions
    large_phase(2047, 3);
    large_phase(1, 1024);

    hold_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (rotor.pending() != 0)
      rotor.report($sformatf("%0d bytes still expected at the end", rotor.pending()));

    $display("covered %0d pixel beats, %0d rotated beats, %0d register writes",
             rotor.pixels_in, rotor.rotated_out, rotor.reg_writes);
    $display("full regions from 2x2 to 14x14, clamped and odd sizes, partial regions at %s",
             "the largest sizes, stalls both sides");
    if (rotor.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/nv21r_pkg.sv
rtl/core/nv21r_ram.sv
rtl/core/nv21r_seq.sv
rtl/core/nv21r_out.sv
rtl/core/nv21_region_rotate_180.sv
tb/nv21_region_rotate_180_tb.sv
